// ----- hdl/lhpc_pkg.sv -----
package lhpc_pkg;

  // Height command codes
  localparam logic [2:0] CMD_HOME    = 3'd0;
  localparam logic [2:0] CMD_COLLECT = 3'd1;
  localparam logic [2:0] CMD_DRIVE   = 3'd2;
  localparam logic [2:0] CMD_LOW     = 3'd3;
  localparam logic [2:0] CMD_MED     = 3'd4;
  localparam logic [2:0] CMD_HIGH    = 3'd5;
  localparam logic [2:0] CMD_CENTER  = 3'd6;

  // Configuration register indexes
  localparam logic [2:0] REG_FULL_SPEED   = 3'd0;
  localparam logic [2:0] REG_DEAD_ZONE    = 3'd1;
  localparam logic [2:0] REG_FULL_ERROR   = 3'd2;
  localparam logic [2:0] REG_ROBOT_HEIGHT = 3'd3;
  localparam logic [2:0] REG_CALIB_STEP   = 3'd4;
  localparam logic [2:0] REG_HOME_OFFSET  = 3'd5;
  localparam logic [2:0] REG_HOME_TIMEOUT = 3'd6;
  localparam logic [2:0] REG_TELEOP_MODE  = 3'd7;

  // Preset heights in encoder counts
  localparam int HEIGHT_COLLECT   = 1;
  localparam int HEIGHT_DRIVE     = 1250;
  localparam int HEIGHT_LOW       = 5900;
  localparam int HEIGHT_MED       = 9600;
  localparam int HEIGHT_HIGH_BASE = 13000;
  localparam int HEIGHT_CENTER    = 13100;

  localparam int SPEED_BITS     = 7;
  localparam int FULL_ERR_BITS  = 11;
  localparam int LAST_ERR_BITS  = 12;
  localparam int CFG_DATA_BITS  = 18;

  // Request to the proportional-band scaler
  typedef struct packed {
    logic                     start;
    logic [FULL_ERR_BITS-1:0] err_mag;
    logic [SPEED_BITS-1:0]    speed;
    logic [FULL_ERR_BITS-1:0] full_error;
  } scale_req_t;

  typedef struct packed {
    logic                  done;
    logic [SPEED_BITS-1:0] quotient;
  } scale_rsp_t;

  // Creep speed: x/5 as (x*205)>>10, exact for 7-bit x
  function automatic logic [SPEED_BITS-1:0] div5(input logic [SPEED_BITS-1:0] x);
    logic [14:0] p;
    p = 15'(x) * 15'd205;
    return SPEED_BITS'(p[14:10]);
  endfunction

endpackage

// ----- hdl/lhpc_scale.sv -----
// Serial scaler: quotient = (err_mag * speed) / full_error, with err_mag < full_error.
// Product, remainder load, then seven restoring-division steps on a shared subtractor.
module lhpc_scale
  import lhpc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  scale_req_t req,
  output scale_rsp_t rsp
);

  localparam int PROD_BITS = FULL_ERR_BITS + SPEED_BITS;

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_DIV} state_t;

  state_t                   state;
  logic [PROD_BITS-1:0]     prod;
  logic [FULL_ERR_BITS-1:0] rem;
  logic [FULL_ERR_BITS-1:0] divisor;
  logic [SPEED_BITS-1:0]    low_bits;
  logic [SPEED_BITS-1:0]    quot;
  logic [2:0]               count;
  logic                     done;

  // Trial subtraction of the shifted remainder
  logic [FULL_ERR_BITS+1:0] trial;
  logic                     fits;

  assign trial = {1'b0, rem, low_bits[SPEED_BITS-1]} - {2'b00, divisor};
  assign fits  = ~trial[FULL_ERR_BITS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (req.start) begin
            prod    <= PROD_BITS'(req.err_mag) * PROD_BITS'(req.speed);
            divisor <= req.full_error;
            state   <= S_MUL;
          end
        end
        S_MUL: begin
          // upper bits are already below the divisor
          rem      <= prod[PROD_BITS-1:SPEED_BITS];
          low_bits <= prod[SPEED_BITS-1:0];
          quot     <= '0;
          count    <= 3'(SPEED_BITS);
          state    <= S_DIV;
        end
        S_DIV: begin
          if (fits) begin
            rem <= trial[FULL_ERR_BITS-1:0];
          end else begin
            rem <= {rem[FULL_ERR_BITS-2:0], low_bits[SPEED_BITS-1]};
          end
          quot     <= {quot[SPEED_BITS-2:0], fits};
          low_bits <= {low_bits[SPEED_BITS-2:0], 1'b0};
          count    <= count - 3'd1;
          if (count == 3'd1) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quot;

endmodule

// ----- hdl/lift_homing_position_controller.sv -----
// Lift homing and position controller. Each input transfer is one control tick and
// produces exactly one output transfer. After reset the lift homes: it drives down at
// -full_speed until the bottom switch closes (position zeroed), then creeps up at
// full_speed/5 until the switch opens (position set to home_offset), and becomes ready
// on the collect preset. A downward homing lasting home_timeout_ticks latches
// home_failed and forces the drive to zero until reset. When running, the lift is
// driven toward the active preset: no drive inside dead_zone, full speed at or beyond
// full_error, and |err|*full_speed/full_error in between. Ticks are processed one at a
// time by a step sequencer: each tick passes raise and lower calibration, command
// intake, a position sample and a mode step; a running tick then evaluates its error
// band, and a tick in the proportional band waits for the serial scaler's product,
// remainder load, seven quotient steps and done flag. A second position sample precedes
// the output register; the input is ready again as soon as the result is registered.
// A new tick is accepted while the previous result still waits at the output register;
// if that result is still waiting when the next one is ready, the sequencer holds in its
// last step until out_ready. Configuration writes are accepted every cycle.
module lift_homing_position_controller
  import lhpc_pkg::*;
#(
  parameter int POSITION_BITS = 20,
  parameter int CALIB_BITS    = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  // tick input
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [19:0]       encoder_count,
  input  logic                     touch_pressed,
  input  logic                     command_valid,
  input  logic [2:0]               command_code,
  input  logic                     reset_request,
  input  logic                     raise_high,
  input  logic                     lower_high,
  // result output
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [7:0]        motor_drive,
  output logic                     ready_res,
  output logic                     at_target,
  output logic                     above_robot,
  output logic                     drive_inhibit,
  output logic                     command_accepted,
  output logic                     home_failed,
  output logic [2:0]               active_command,
  // configuration writes
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [2:0]               cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  localparam int PW      = POSITION_BITS;
  localparam int ENC_EXT = 33;
  localparam int HW      = ((CALIB_BITS > 15) ? CALIB_BITS : 15) + 1;
  localparam int EW      = ((HW > PW) ? HW : PW) + 1;
  localparam int SW      = CALIB_BITS + 2;
  localparam int CW      = ((PW > 19) ? PW : 19) + 1;

  typedef enum logic [1:0] {M_DOWN, M_UP, M_RUN} mode_t;
  typedef enum logic [3:0] {
    ST_IDLE, ST_RAISE, ST_LOWER, ST_CMD, ST_POS, ST_STEP, ST_EVAL, ST_DIV, ST_POS2, ST_OUT
  } seq_t;

  // configuration registers
  logic [6:0]  full_speed;
  logic [9:0]  dead_zone;
  logic [10:0] full_error;
  logic [17:0] robot_height;
  logic [9:0]  calib_step;
  logic [9:0]  home_offset;
  logic [15:0] home_timeout_ticks;
  logic        teleop_mode;

  // captured tick
  logic signed [19:0] enc_q;
  logic               touch_q, cvalid_q, rreq_q, raise_q, lower_q;
  logic [2:0]         code_q;

  // controller state
  seq_t                             seq;
  mode_t                            mode;
  logic [2:0]                       cur_cmd;
  logic                             ready_flag, failed_flag, target_flag;
  logic [15:0]                      home_timer;
  logic signed [PW-1:0]             zero_offset;
  logic signed [CALIB_BITS-1:0]     calibration;
  logic signed [LAST_ERR_BITS-1:0]  last_error;

  // working registers
  logic signed [PW-1:0] pos_q;
  logic signed [EW-1:0] err_q;
  logic signed [7:0]    drive_q;
  logic                 acc_q;

  scale_req_t scale_req;
  scale_rsp_t scale_rsp;

  assign cfg_ready = 1'b1;
  assign in_ready  = (seq == ST_IDLE);

  // Encoder wrapped to position width
  logic [ENC_EXT-1:0]   enc_ext;
  logic signed [PW-1:0] enc_pw;
  logic signed [PW-1:0] enc_rel;
  assign enc_ext = ENC_EXT'(enc_q);
  assign enc_pw  = enc_ext[PW-1:0];
  assign enc_rel = enc_pw - zero_offset;

  logic [6:0] speed;
  assign speed = failed_flag ? 7'd0 : full_speed;

  // Shared saturating adder for high-preset calibration
  logic signed [SW-1:0] step_s, cal_sum, cal_sat;
  assign step_s  = $signed(SW'(calib_step));
  assign cal_sum = SW'(calibration) + ((seq == ST_RAISE) ? step_s : -step_s)
                   + SW'(last_error);
  always_comb begin
    if (cal_sum > SW'((2 ** (CALIB_BITS - 1)) - 1)) begin
      cal_sat = SW'((2 ** (CALIB_BITS - 1)) - 1);
    end else if (cal_sum < -SW'(2 ** (CALIB_BITS - 1))) begin
      cal_sat = -SW'(2 ** (CALIB_BITS - 1));
    end else begin
      cal_sat = cal_sum;
    end
  end

  // Reset request, then command intake
  logic [2:0]  cmd_next;
  logic        ready_next, acc_next, clear_target;
  mode_t       mode_next;
  logic [15:0] timer_next;
  always_comb begin
    cmd_next     = cur_cmd;
    ready_next   = ready_flag;
    mode_next    = mode;
    timer_next   = home_timer;
    acc_next     = 1'b0;
    clear_target = 1'b0;
    if (rreq_q) begin
      ready_next = 1'b0;
      cmd_next   = CMD_HOME;
      if (mode == M_RUN && !failed_flag) begin
        mode_next  = M_DOWN;
        timer_next = '0;
      end
    end
    if (cvalid_q && ready_next && code_q inside {[CMD_HOME:CMD_CENTER]}) begin
      acc_next     = 1'b1;
      clear_target = 1'b1;
      cmd_next     = code_q;
      if (code_q == CMD_HOME && mode_next == M_RUN && !failed_flag) begin
        mode_next  = M_DOWN;
        timer_next = '0;
      end
    end
  end

  // Homing timer and timeout
  logic [15:0] timer_inc;
  logic        fail_now;
  assign timer_inc = (home_timer != 16'hFFFF) ? home_timer + 16'd1 : home_timer;
  assign fail_now  = failed_flag | (timer_inc >= home_timeout_ticks);

  // Preset height of the active command
  logic signed [HW-1:0] height;
  always_comb begin
    case (cur_cmd)
      CMD_COLLECT: height = HW'(HEIGHT_COLLECT);
      CMD_DRIVE:   height = HW'(HEIGHT_DRIVE);
      CMD_LOW:     height = HW'(HEIGHT_LOW);
      CMD_MED:     height = HW'(HEIGHT_MED);
      CMD_HIGH:    height = HW'(HEIGHT_HIGH_BASE) + HW'(calibration);
      CMD_CENTER:  height = HW'(HEIGHT_CENTER);
      default:     height = '0;
    endcase
  end

  // Error magnitude and band
  logic [EW-1:0] err_mag;
  logic          err_neg, in_dead, in_full;
  assign err_neg = err_q[EW-1];
  assign err_mag = err_neg ? EW'(-err_q) : EW'(err_q);
  assign in_dead = err_mag < EW'(dead_zone);
  assign in_full = err_mag >= EW'(full_error);

  assign scale_req.start      = (seq == ST_EVAL) && !in_dead && !in_full;
  assign scale_req.err_mag    = err_mag[FULL_ERR_BITS-1:0];
  assign scale_req.speed      = speed;
  assign scale_req.full_error = full_error;

  lhpc_scale u_scale (
    .clk (clk),
    .rst (rst),
    .req (scale_req),
    .rsp (scale_rsp)
  );

  logic signed [7:0] speed_s, quot_s;
  assign speed_s = $signed({1'b0, speed});
  assign quot_s  = $signed({1'b0, scale_rsp.quotient});

  // Above-robot compare
  logic signed [CW-1:0] pos_c, rh_c;
  assign pos_c = CW'(pos_q);
  assign rh_c  = $signed(CW'(robot_height));

  // Configuration register file
  always_ff @(posedge clk) begin
    if (rst) begin
      full_speed         <= 7'd100;
      dead_zone          <= 10'd50;
      full_error         <= 11'd100;
      robot_height       <= 18'd5200;
      calib_step         <= 10'd150;
      home_offset        <= 10'd25;
      home_timeout_ticks <= 16'd4000;
      teleop_mode        <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FULL_SPEED:   full_speed         <= cfg_data[6:0];
        REG_DEAD_ZONE:    dead_zone          <= cfg_data[9:0];
        REG_FULL_ERROR:   full_error         <= cfg_data[10:0];
        REG_ROBOT_HEIGHT: robot_height       <= cfg_data[17:0];
        REG_CALIB_STEP:   calib_step         <= cfg_data[9:0];
        REG_HOME_OFFSET:  home_offset        <= cfg_data[9:0];
        REG_HOME_TIMEOUT: home_timeout_ticks <= cfg_data[15:0];
        REG_TELEOP_MODE:  teleop_mode        <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Tick sequencer, controller state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      seq         <= ST_IDLE;
      mode        <= M_DOWN;
      cur_cmd     <= CMD_HOME;
      ready_flag  <= 1'b0;
      failed_flag <= 1'b0;
      target_flag <= 1'b0;
      home_timer  <= '0;
      zero_offset <= '0;
      calibration <= '0;
      last_error  <= '0;
      out_valid   <= 1'b0;
    end else begin
      // result leaves; in ST_OUT the next one takes its place instead
      if (out_valid && out_ready && seq != ST_OUT) begin
        out_valid <= 1'b0;
      end
      case (seq)
        ST_IDLE: begin
          if (in_valid) begin
            enc_q    <= encoder_count;
            touch_q  <= touch_pressed;
            cvalid_q <= command_valid;
            code_q   <= command_code;
            rreq_q   <= reset_request;
            raise_q  <= raise_high;
            lower_q  <= lower_high;
            seq      <= ST_RAISE;
          end
        end
        ST_RAISE: begin
          if (raise_q) calibration <= cal_sat[CALIB_BITS-1:0];
          seq <= ST_LOWER;
        end
        ST_LOWER: begin
          if (lower_q) calibration <= cal_sat[CALIB_BITS-1:0];
          seq <= ST_CMD;
        end
        ST_CMD: begin
          cur_cmd    <= cmd_next;
          ready_flag <= ready_next;
          mode       <= mode_next;
          home_timer <= timer_next;
          acc_q      <= acc_next;
          if (clear_target) target_flag <= 1'b0;
          drive_q <= '0;
          seq     <= ST_POS;
        end
        ST_POS: begin
          pos_q <= enc_rel;
          seq   <= ST_STEP;
        end
        ST_STEP: begin
          case (mode)
            M_DOWN: begin
              if (touch_q) begin
                zero_offset <= enc_pw;
                mode        <= M_UP;
              end else begin
                home_timer  <= timer_inc;
                failed_flag <= fail_now;
                drive_q     <= fail_now ? 8'sd0 : -$signed({1'b0, full_speed});
              end
              seq <= ST_POS2;
            end
            M_UP: begin
              if (touch_q) begin
                drive_q <= $signed({1'b0, div5(speed)});
              end else begin
                zero_offset <= enc_pw - PW'(home_offset);
                mode        <= M_RUN;
                ready_flag  <= !failed_flag;
                cur_cmd     <= failed_flag ? CMD_HOME : CMD_COLLECT;
              end
              seq <= ST_POS2;
            end
            default: begin
              err_q <= EW'(height) - EW'(pos_q);
              seq   <= ST_EVAL;
            end
          endcase
        end
        ST_EVAL: begin
          if (in_dead) begin
            target_flag <= 1'b1;
            last_error  <= err_q[LAST_ERR_BITS-1:0];
            drive_q     <= '0;
            seq         <= ST_POS2;
          end else begin
            target_flag <= 1'b0;
            if (in_full) begin
              drive_q <= err_neg ? -speed_s : speed_s;
              seq     <= ST_POS2;
            end else begin
              seq <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          if (scale_rsp.done) begin
            drive_q <= err_neg ? -quot_s : quot_s;
            seq     <= ST_POS2;
          end
        end
        ST_POS2: begin
          pos_q <= enc_rel;
          seq   <= ST_OUT;
        end
        ST_OUT: begin
          if (!out_valid || out_ready) begin
            motor_drive      <= drive_q;
            ready_res        <= ready_flag;
            at_target        <= ready_flag & target_flag;
            above_robot      <= pos_c > rh_c;
            drive_inhibit    <= (pos_c > rh_c) & teleop_mode;
            command_accepted <= acc_q;
            home_failed      <= failed_flag;
            active_command   <= ready_flag ? cur_cmd : CMD_HOME;
            out_valid        <= 1'b1;
            seq              <= ST_IDLE;
          end
        end
        default: seq <= ST_IDLE;
      endcase
    end
  end

  // A tick is processed alone: no accept right after an accept
  a_one_tick: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("tick accepted while previous tick in progress");

  // Latched failure never drives the motor
  a_fail_stop: assert property (@(posedge clk) disable iff (rst)
    out_valid && home_failed |-> motor_drive == 8'sd0)
    else $error("motor driven after homing failure");

  // On target only when ready
  a_target_ready: assert property (@(posedge clk) disable iff (rst)
    out_valid && at_target |-> ready_res)
    else $error("at_target without ready");

  // No active command while not ready
  a_cmd_ready: assert property (@(posedge clk) disable iff (rst)
    out_valid && !ready_res |-> active_command == CMD_HOME)
    else $error("active command reported while not ready");

endmodule
